// File: rtl/sobm_pkg.sv
package sobm_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_GAIN         = 2'd2;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [15:0] GAIN_RESET   = 16'd256;
  localparam logic [12:0] HEIGHT_MAX   = 13'd4096;

  localparam int GradW = 12;

  typedef logic [7:0] pixel_t;

  typedef struct packed {
    logic                    start;
    logic signed [GradW-1:0] u;
    logic signed [GradW-1:0] v;
  } mag_req_t;

endpackage

// File: rtl/sobm_ram.sv
module sobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/sobm_mag.sv
module sobm_mag (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sobm_pkg::mag_req_t req_i,
  input  logic [15:0]        gain_i,
  output logic               done_o,
  output logic [7:0]         edge_o
);

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_SQ   = 3'd1;
  localparam logic [2:0] M_G1   = 3'd2;
  localparam logic [2:0] M_G2   = 3'd3;
  localparam logic [2:0] M_CHK  = 3'd4;
  localparam logic [2:0] M_ROOT = 3'd5;

  logic [2:0] state_q, state_d;
  logic signed [sobm_pkg::GradW-1:0] u_q, v_q;
  logic signed [2*sobm_pkg::GradW-1:0] uu, vv;
  logic [20:0] sq_q;
  logic [36:0] p1_q;
  logic [52:0] n_q;
  logic [31:0] num_q, res_q, bit_q;
  logic [3:0]  step_q;
  logic [32:0] trial;
  logic        done_q;
  logic [7:0]  edge_q;

  assign uu    = u_q * u_q;
  assign vv    = v_q * v_q;
  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE:  if (req_i.start) state_d = M_SQ;
      M_SQ:    state_d = M_G1;
      M_G1:    state_d = M_G2;
      M_G2:    state_d = M_CHK;
      M_CHK:   state_d = (|n_q[52:32]) ? M_IDLE : M_ROOT;
      M_ROOT:  if (step_q == 4'd15) state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_CHK && (|n_q[52:32])) ||
                 (state_q == M_ROOT && step_q == 4'd15);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      M_IDLE: begin
        u_q <= req_i.u;
        v_q <= req_i.v;
      end
      M_SQ: sq_q <= 21'(uu) + 21'(vv);
      M_G1: p1_q <= 37'(sq_q) * 37'(gain_i);
      M_G2: n_q  <= 53'(p1_q) * 53'(gain_i);
      M_CHK: begin
        num_q  <= n_q[31:0];
        res_q  <= '0;
        bit_q  <= 32'h4000_0000;
        step_q <= '0;
        edge_q <= 8'hFF;
      end
      M_ROOT: begin
        // one result bit per cycle
        if ({1'b0, num_q} >= trial) begin
          num_q <= num_q - trial[31:0];
          res_q <= (res_q >> 1) + bit_q;
          if (step_q == 4'd15) edge_q <= 8'(((res_q >> 1) + bit_q) >> 8);
        end else begin
          res_q <= res_q >> 1;
          if (step_q == 4'd15) edge_q <= 8'(res_q >> 9);
        end
        bit_q  <= bit_q >> 2;
        step_q <= step_q + 4'd1;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign edge_o = edge_q;

endmodule

// File: rtl/sobel_edge_magnitude_top.sv
// Sobel edge magnitude, 3x3 window with replicated border.
// Input channel s_axis: one request per pixel in raster order; tuser set marks
// a drain request. After a frame send frame_width + 1 drain requests to flush
// the trailing outputs; the output carrying tlast closes the frame.
// Output channel m_axis: edge magnitude min(255, isqrt((U*U+V*V)*gain^2)>>8).
// Result k leaves for the request that carries input k + frame_width + 1.
// Config channel: cfg_index 0 width, 1 height, 2 gain (8.8); write only
// between frames while the block is idle.
// One request is in flight at a time. A request without a result ends after
// the read step and a dropped drain ends at once; one with a result waits for
// the 16-step bit-serial square root unless the product saturates.
// The two line stores are single-port-write RAMs read in the cycle before the
// read-modify-write, so no forwarding is needed.
// Reset clears position, window and output valid and loads the default
// width 640, height 480, gain 1.0. A stalled output holds its result; the
// next request is still taken and worked on, then waits for the slot.
module sobel_edge_magnitude_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tuser,   // [0] op (drain)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] edge_res
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [15:0] gain_q;
  logic [CW-1:0] col_q, ic_q;
  logic [12:0]   row_q, ir_q;
  sobm_pkg::pixel_t px_q;
  sobm_pkg::pixel_t win_q [3][3];
  sobm_pkg::pixel_t nw2 [3];
  sobm_pkg::pixel_t opl [3], opc [3], opr [3];
  sobm_pkg::pixel_t above_rd, mid_rd;

  logic [CW-1:0] w_eff, col_a;
  logic [12:0]   h_eff;
  logic [13:0]   h1, row_a;
  logic          accept, skip, rd_act;
  logic          wr_en, case_a, case_b, shift, have, last_d, last_q;
  logic          m_valid_q, m_last_q;
  logic [7:0]    m_data_q, res_q;
  logic signed [sobm_pkg::GradW-1:0] u_d, v_d;
  sobm_pkg::mag_req_t req;
  logic          mag_done;
  logic [7:0]    mag_edge;
  logic [CW:0]   col_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Clamp configuration and renormalise the position
  always_comb begin
    if (width_q == '0) w_eff = CW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    if (height_q == '0) h_eff = 13'd1;
    else if (height_q > sobm_pkg::HEIGHT_MAX) h_eff = sobm_pkg::HEIGHT_MAX;
    else h_eff = height_q;
    h1 = {1'b0, h_eff} + 14'd1;
    col_a = col_q;
    row_a = {1'b0, row_q};
    if (col_q >= w_eff) begin
      col_a = '0;
      row_a = {1'b0, row_q} + 14'd1;
    end
    if (row_a > h1 || (row_a == h1 && col_a != '0)) begin
      col_a = '0;
      row_a = '0;
    end
    skip = s_axis_tuser && (row_a < {1'b0, h_eff});
  end

  sobm_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_above (
    .clk_i   (clk_i),
    .we_i    (rd_act && wr_en && ir_q != '0),
    .waddr_i (ic_q[AW-1:0]),
    .wdata_i (mid_rd),
    .raddr_i (col_a[AW-1:0]),
    .rdata_o (above_rd)
  );

  sobm_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_middle (
    .clk_i   (clk_i),
    .we_i    (rd_act && wr_en),
    .waddr_i (ic_q[AW-1:0]),
    .wdata_i (px_q),
    .raddr_i (col_a[AW-1:0]),
    .rdata_o (mid_rd)
  );

  // Read-modify-write step: line stores, window, operand pick
  always_comb begin
    rd_act = (state_q == ST_RD);
    wr_en  = ir_q < h_eff;
    shift  = ir_q != '0 && ir_q <= h_eff;
    case_a = ic_q == '0 && ir_q >= 13'd2;
    case_b = shift && ic_q != '0;
    have   = case_a || case_b;
    last_d = case_a && {1'b0, ir_q} == h1;
    nw2[0] = (ir_q == 13'd1) ? mid_rd : above_rd;
    nw2[1] = mid_rd;
    nw2[2] = wr_en ? px_q : mid_rd;
    if (case_a) begin
      opl = (w_eff == CW'(1)) ? win_q[2] : win_q[1];
      opc = win_q[2];
      opr = win_q[2];
    end else begin
      opl = (ic_q == CW'(1)) ? win_q[2] : win_q[1];
      opc = win_q[2];
      opr = nw2;
      if (ic_q == CW'(1)) opl = win_q[2];
      opc = win_q[2];
    end
    u_d = (12'(opl[0]) + {3'b0, opl[1], 1'b0} + 12'(opl[2]))
        - (12'(opr[0]) + {3'b0, opr[1], 1'b0} + 12'(opr[2]));
    v_d = (12'(opl[0]) + {3'b0, opc[0], 1'b0} + 12'(opr[0]))
        - (12'(opl[2]) + {3'b0, opc[2], 1'b0} + 12'(opr[2]));
    col_inc = {1'b0, ic_q} + 1'b1;
  end

  // For the interior case the new window is left=win[1], centre=win[2],
  // right=new column; left doubles as centre in the first column.
  always_comb begin
    req.start = rd_act && have;
    req.u     = u_d;
    req.v     = v_d;
  end

  sobm_mag u_mag (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .gain_i (gain_q),
    .done_o (mag_done),
    .edge_o (mag_edge)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && !skip) state_d = ST_RD;
      ST_RD:   state_d = have ? ST_CALC : ST_IDLE;
      ST_CALC: if (mag_done) state_d = ST_OUT;
      ST_OUT:  if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      width_q   <= sobm_pkg::WIDTH_RESET;
      height_q  <= sobm_pkg::HEIGHT_RESET;
      gain_q    <= sobm_pkg::GAIN_RESET;
      col_q     <= '0;
      row_q     <= '0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          sobm_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[10:0];
          sobm_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i[12:0];
          sobm_pkg::CFG_GAIN:         gain_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_a;
        row_q <= row_a[12:0];
      end
      if (rd_act) begin
        if (shift) begin
          win_q[0] <= win_q[1];
          win_q[1] <= win_q[2];
          win_q[2] <= nw2;
        end
        // advance the position, restart the frame after its last output
        if (last_d) begin
          col_q <= '0;
          row_q <= '0;
        end else if (col_inc >= {1'b0, w_eff}) begin
          col_q <= '0;
          row_q <= ir_q + 13'd1;
        end else begin
          col_q <= col_inc[CW-1:0];
        end
      end
      if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ic_q <= col_a;
      ir_q <= row_a[12:0];
      px_q <= s_axis_tdata;
    end
    if (rd_act) last_q <= last_d;
    if (state_q == ST_CALC && mag_done) res_q <= mag_edge;
    if (state_q == ST_OUT && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= res_q;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

`ifndef SYNTH
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_done |-> state_q == ST_CALC)
    else $error("magnitude result outside calculation");
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RD || state_q == ST_IDLE))
    else $error("bad state after request");
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("output raised without a result");
`endif

endmodule
